@@ sv/ictf_pkg.sv @@
`default_nettype none
package ictf_pkg;

  localparam int unsigned TableLen = 24;
  localparam int unsigned TableFrac = 24;

  // Arctangent of 2^-i in degrees, Q24.
  function automatic logic [31:0] atan_q24(input logic [4:0] idx);
    logic [31:0] v;
    begin
      case (idx)
        5'd0: v = 32'd754974720;
        5'd1: v = 32'd445687602;
        5'd2: v = 32'd235489088;
        5'd3: v = 32'd119537938;
        5'd4: v = 32'd60000934;
        5'd5: v = 32'd30029717;
        5'd6: v = 32'd15018523;
        5'd7: v = 32'd7509720;
        5'd8: v = 32'd3754917;
        5'd9: v = 32'd1877466;
        5'd10: v = 32'd938734;
        5'd11: v = 32'd469367;
        5'd12: v = 32'd234684;
        5'd13: v = 32'd117342;
        5'd14: v = 32'd58671;
        5'd15: v = 32'd29335;
        5'd16: v = 32'd14668;
        5'd17: v = 32'd7334;
        5'd18: v = 32'd3667;
        5'd19: v = 32'd1833;
        5'd20: v = 32'd917;
        5'd21: v = 32'd458;
        5'd22: v = 32'd229;
        5'd23: v = 32'd115;
        default: v = 32'd0;
      endcase
      return v;
    end
  endfunction

  typedef enum logic [2:0] {
    REG_WEIGHT = 3'd0,
    REG_GAIN   = 3'd1,
    REG_OFFR   = 3'd2,
    REG_OFFP   = 3'd3,
    REG_OFFX   = 3'd4,
    REG_OFFY   = 3'd5,
    REG_OFFZ   = 3'd6
  } reg_idx_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SQRT,
    ST_CORDIC,
    ST_TILT,
    ST_MUL,
    ST_DIV,
    ST_DELTA,
    ST_BLEND,
    ST_NEXT,
    ST_OUT
  } state_t;

endpackage
`default_nettype wire

@@ sv/imu_complementary_tilt_filter_core.sv @@
`default_nettype none
// Complementary tilt filter. One item in, one item out: roll and pitch blend
// CORDIC accelerometer tilt with integrated gyro rate, yaw integrates gyro z.
// Each item is processed step by step: for each of roll and pitch, squares and a
// bit-serial square root, CORDIC, tilt, a multiply, a bit-serial divide by one
// million and the blend; for yaw, only the multiply and the divide. The divides
// are the longest steps. The result is held in an output register, so a new
// item is taken while the previous result waits.
module imu_complementary_tilt_filter_core #(
  parameter int unsigned CORDIC_STEPS    = 16,
  parameter int unsigned ANGLE_FRAC_BITS = 16
) (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         in_tvalid,
  output logic              in_tready,
  // accel_x, accel_y, accel_z, rate_x, rate_y, rate_z, elapsed_us
  input  wire logic [111:0] in_tdata,
  output logic              out_tvalid,
  input  wire logic         out_tready,
  // roll_deg, pitch_deg, yaw_deg
  output logic [95:0]       out_tdata,
  input  wire logic         cfg_psel,
  input  wire logic         cfg_penable,
  input  wire logic         cfg_pwrite,
  input  wire logic [4:0]   cfg_paddr,
  input  wire logic [31:0]  cfg_pwdata,
  output logic [31:0]       cfg_prdata,
  output logic              cfg_pready
);
  localparam int unsigned SH = ictf_pkg::TableFrac - ANGLE_FRAC_BITS;

  logic [16:0] weight_r;
  logic [31:0] gain_r, offr_r, offp_r;
  logic [15:0] offx_r, offy_r, offz_r;
  logic        wr;
  assign cfg_pready = 1'b1;
  assign wr = cfg_psel && cfg_penable && cfg_pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      weight_r <= 17'd64225; gain_r <= '0; offr_r <= '0; offp_r <= '0;
      offx_r <= '0; offy_r <= '0; offz_r <= '0;
    end else if (wr && cfg_paddr[1:0] == 2'b00) begin
      unique case (cfg_paddr[4:2])
        ictf_pkg::REG_WEIGHT: weight_r <= cfg_pwdata[16:0];
        ictf_pkg::REG_GAIN:   gain_r   <= cfg_pwdata;
        ictf_pkg::REG_OFFR:   offr_r   <= cfg_pwdata;
        ictf_pkg::REG_OFFP:   offp_r   <= cfg_pwdata;
        ictf_pkg::REG_OFFX:   offx_r   <= cfg_pwdata[15:0];
        ictf_pkg::REG_OFFY:   offy_r   <= cfg_pwdata[15:0];
        ictf_pkg::REG_OFFZ:   offz_r   <= cfg_pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_paddr[4:2])
      ictf_pkg::REG_WEIGHT: cfg_prdata = {15'b0, weight_r};
      ictf_pkg::REG_GAIN:   cfg_prdata = gain_r;
      ictf_pkg::REG_OFFR:   cfg_prdata = offr_r;
      ictf_pkg::REG_OFFP:   cfg_prdata = offp_r;
      ictf_pkg::REG_OFFX:   cfg_prdata = {{16{offx_r[15]}}, offx_r};
      ictf_pkg::REG_OFFY:   cfg_prdata = {{16{offy_r[15]}}, offy_r};
      ictf_pkg::REG_OFFZ:   cfg_prdata = {{16{offz_r[15]}}, offz_r};
      default: cfg_prdata = '0;
    endcase
  end

  // Sample and state.
  logic [111:0] smp_r;
  logic [31:0]  roll_r, pitch_r, yaw_r;
  logic [1:0]   ax_r;       // axis: 0 roll, 1 pitch, 2 yaw
  ictf_pkg::state_t st_r, st_nxt;
  logic signed [32:0] tilt_r;
  logic signed [63:0] m_r;
  logic         neg_r;
  logic signed [43:0] d_r;
  logic [95:0]  out_r;
  logic         ov_r;
  logic         out_fire;

  logic signed [16:0] ax16, ay16, az16, gsel, opp;
  logic signed [16:0] sa, sb;
  logic [16:0]  gmag;
  logic [47:0]  rad;
  logic         acc;

  assign ax16 = {smp_r[15], smp_r[15:0]};
  assign ay16 = {smp_r[31], smp_r[31:16]};
  assign az16 = {smp_r[47], smp_r[47:32]};
  assign acc = in_tvalid && in_tready;
  assign in_tready = (st_r == ictf_pkg::ST_IDLE);
  // post the result once the output register is free or being emptied
  assign out_fire = (st_r == ictf_pkg::ST_OUT) && (!ov_r || out_tready);

  always_comb begin
    unique case (ax_r)
      2'd0: gsel = $signed({smp_r[63], smp_r[63:48]}) - $signed({offx_r[15], offx_r});
      2'd1: gsel = $signed({smp_r[79], smp_r[79:64]}) - $signed({offy_r[15], offy_r});
      default: gsel = $signed({smp_r[95], smp_r[95:80]}) - $signed({offz_r[15], offz_r});
    endcase
    gmag = gsel[16] ? 17'(-gsel) : gsel;
    if (ax_r == 2'd0) begin
      opp = ay16; sa = ax16; sb = az16;
    end else begin
      opp = -ax16; sa = ay16; sb = az16;
    end
  end

  // Squares are formed through sq_r into the radicand register.
  logic [32:0] sq_r;
  logic [47:0] rad_r;
  assign rad = rad_r;

  // Units.
  logic sq_start, sq_done, co_start, co_done, dv_start, dv_done;
  logic [23:0] root;
  logic signed [31:0] angle;
  logic [63:0] quot;
  logic [63:0] divin_r;

  ictf_sqrt u_sqrt (.clk(clk), .rst_n(rst_n), .start(sq_start), .radicand(rad),
    .done(sq_done), .root(root));
  ictf_cordic #(.STEPS(CORDIC_STEPS), .FRAC(ANGLE_FRAC_BITS)) u_cordic (
    .clk(clk), .rst_n(rst_n), .start(co_start), .x_in(root),
    .y_in({opp, 8'b0}), .done(co_done), .angle(angle));
  ictf_divu u_div (.clk(clk), .rst_n(rst_n), .start(dv_start), .dividend(divin_r),
    .done(dv_done), .quot(quot));

  // Sub-step counter for short multi-cycle steps.
  logic [1:0] k_r;

  always_comb begin
    st_nxt = st_r;
    unique case (st_r)
      ictf_pkg::ST_IDLE:   if (acc) st_nxt = ictf_pkg::ST_SQRT;
      ictf_pkg::ST_SQRT:   if (sq_done) st_nxt = ictf_pkg::ST_CORDIC;
      ictf_pkg::ST_CORDIC: if (co_done) st_nxt = ictf_pkg::ST_TILT;
      ictf_pkg::ST_TILT:   st_nxt = ictf_pkg::ST_MUL;
      ictf_pkg::ST_MUL:    if (k_r == 2'd2) st_nxt = ictf_pkg::ST_DIV;
      ictf_pkg::ST_DIV:    if (dv_done) st_nxt = ictf_pkg::ST_DELTA;
      ictf_pkg::ST_DELTA:  st_nxt = (ax_r == 2'd2) ? ictf_pkg::ST_NEXT : ictf_pkg::ST_BLEND;
      ictf_pkg::ST_BLEND:  if (k_r == 2'd2) st_nxt = ictf_pkg::ST_NEXT;
      ictf_pkg::ST_NEXT:   st_nxt = (ax_r == 2'd2) ? ictf_pkg::ST_OUT :
                                   (ax_r == 2'd1) ? ictf_pkg::ST_MUL : ictf_pkg::ST_SQRT;
      ictf_pkg::ST_OUT:    if (!ov_r || out_tready) st_nxt = ictf_pkg::ST_IDLE;
      default:             st_nxt = ictf_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    sq_start = 1'b0;
    co_start = 1'b0;
    dv_start = 1'b0;
    unique case (st_r)
      ictf_pkg::ST_SQRT:   sq_start = (k_r == 2'd2);
      ictf_pkg::ST_CORDIC: co_start = (k_r == 2'd0);
      ictf_pkg::ST_DIV:    dv_start = (k_r == 2'd0);
      default: ;
    endcase
  end

  // Blend datapath pieces.
  logic [16:0] w;
  logic signed [43:0] prev_d;
  logic signed [63:0] bl_r;
  logic signed [63:0] rnd;
  logic signed [31:0] sat;
  logic signed [43:0] dr;
  logic signed [43:0] dsg;
  assign w = (weight_r > 17'd65536) ? 17'd65536 : weight_r;
  assign prev_d = (ax_r == 2'd0) ? ($signed({{12{roll_r[31]}}, roll_r}) + d_r)
                                 : ($signed({{12{pitch_r[31]}}, pitch_r}) + d_r);
  assign rnd = (bl_r + 64'sd32768) >>> 16;
  assign sat = (rnd > 64'sd2147483647) ? 32'sh7fffffff :
               (rnd < -64'sd2147483648) ? 32'sh80000000 : rnd[31:0];

  generate
    if (SH == 0) begin : g_dn
      assign dr = $signed({1'b0, quot[42:0]});
    end else begin : g_dr
      assign dr = $signed({1'b0, quot[42:0]} + (44'd1 << (SH - 1))) >>> SH;
    end
  endgenerate
  assign dsg = neg_r ? -dr : dr;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= ictf_pkg::ST_IDLE;
      ax_r <= '0; k_r <= '0; ov_r <= 1'b0;
      roll_r <= '0; pitch_r <= '0; yaw_r <= '0;
    end else begin
      st_r <= st_nxt;
      if (st_nxt != st_r) k_r <= '0;
      else if (k_r != 2'd3) k_r <= k_r + 2'd1;
      if (out_fire) ov_r <= 1'b1;
      else if (out_tvalid && out_tready) ov_r <= 1'b0;
      unique case (st_r)
        ictf_pkg::ST_IDLE: if (acc) ax_r <= '0;
        ictf_pkg::ST_NEXT: if (ax_r != 2'd2) ax_r <= ax_r + 2'd1;
        ictf_pkg::ST_BLEND: if (k_r == 2'd2) begin
          if (ax_r == 2'd0) roll_r <= sat;
          else pitch_r <= sat;
        end
        ictf_pkg::ST_DELTA: if (ax_r == 2'd2) yaw_r <= yaw_r + dsg[31:0];
        default: ;
      endcase
    end
    if (acc) smp_r <= in_tdata;
    // square terms, one multiply per cycle
    if (st_r == ictf_pkg::ST_SQRT && k_r == 2'd0) sq_r <= 33'(sa * sa);
    if (st_r == ictf_pkg::ST_SQRT && k_r == 2'd1)
      rad_r <= 48'({sq_r + 33'(sb * sb), 16'b0});
    if (st_r == ictf_pkg::ST_TILT)
      tilt_r <= $signed({angle[31], angle}) -
                $signed(ax_r == 2'd0 ? {offr_r[31], offr_r} : {offp_r[31], offp_r});
    if (st_r == ictf_pkg::ST_MUL && k_r == 2'd0) begin
      m_r   <= $signed({16'b0, ((gain_r * {15'b0, gmag}) + 48'd2048) >> 12});
      neg_r <= gsel[16];
    end
    if (st_r == ictf_pkg::ST_MUL && k_r == 2'd1)
      divin_r <= 64'(m_r[36:0] * {48'b0, smp_r[111:96]}) ;
    if (st_r == ictf_pkg::ST_MUL && k_r == 2'd2)
      divin_r <= {divin_r[55:0], 8'b0} + 64'd500000;
    if (st_r == ictf_pkg::ST_DELTA) d_r <= dsg;
    if (st_r == ictf_pkg::ST_BLEND && k_r == 2'd0)
      bl_r <= 64'($signed({1'b0, w}) * prev_d);
    if (st_r == ictf_pkg::ST_BLEND && k_r == 2'd1)
      bl_r <= bl_r + 64'($signed({1'b0, 17'd65536 - w}) * tilt_r);
    if (out_fire) out_r <= {yaw_r, pitch_r, roll_r};
  end

  assign out_tvalid = ov_r;
  assign out_tdata  = out_r;

  a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    acc |=> st_r == ictf_pkg::ST_SQRT) else $error("item accepted but not started");
  a_hold_out: assert property (@(posedge clk) disable iff (!rst_n)
    ov_r && !out_tready |=> ov_r && $stable(out_r)) else $error("result dropped");
  a_out_after: assert property (@(posedge clk) disable iff (!rst_n)
    st_r == ictf_pkg::ST_OUT |=> ov_r) else $error("result not posted");
endmodule
`default_nettype wire

@@ sv/ictf_sqrt.sv @@
`default_nettype none
// Bit-serial floor square root: two radicand bits per cycle.
module ictf_sqrt (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        start,
  input  wire logic [47:0] radicand,
  output logic             done,
  output logic [23:0]      root
);
  logic [47:0] rad_r, rad_nxt;
  logic [25:0] rem_r, rem_nxt;
  logic [23:0] root_r, root_nxt;
  logic [4:0]  cnt_r, cnt_nxt;
  logic        busy_r, busy_nxt;
  logic [25:0] trial;
  logic [25:0] rem_sh;

  always_comb begin
    rem_sh   = {rem_r[23:0], rad_r[47:46]};
    trial    = {root_r, 2'b01};
    rad_nxt  = rad_r;
    rem_nxt  = rem_r;
    root_nxt = root_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    if (start) begin
      rad_nxt  = radicand;
      rem_nxt  = '0;
      root_nxt = '0;
      cnt_nxt  = 5'd0;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      rad_nxt = {rad_r[45:0], 2'b00};
      if (rem_sh >= trial) begin
        rem_nxt  = rem_sh - trial;
        root_nxt = {root_r[22:0], 1'b1};
      end else begin
        rem_nxt  = rem_sh;
        root_nxt = {root_r[22:0], 1'b0};
      end
      cnt_nxt = cnt_r + 5'd1;
      if (cnt_r == 5'd23) busy_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      cnt_r  <= cnt_nxt;
    end
    rad_r  <= rad_nxt;
    rem_r  <= rem_nxt;
    root_r <= root_nxt;
  end

  logic busy_d_r;
  always_ff @(posedge clk) begin
    if (!rst_n) busy_d_r <= 1'b0;
    else        busy_d_r <= busy_r;
  end
  assign done = busy_d_r && !busy_r;
  assign root = root_r;

  a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    busy_r |-> cnt_r <= 5'd23) else $error("sqrt count overrun");
  a_done_once: assert property (@(posedge clk) disable iff (!rst_n)
    done |=> !done) else $error("sqrt done twice");
  a_busy_start: assert property (@(posedge clk) disable iff (!rst_n)
    start |=> busy_r) else $error("sqrt did not start");
endmodule
`default_nettype wire

@@ sv/ictf_cordic.sv @@
`default_nettype none
// Vectoring CORDIC, one micro-rotation per cycle on a shared adder set.
module ictf_cordic #(
  parameter int unsigned STEPS = 16,
  parameter int unsigned FRAC  = 16
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               start,
  input  wire logic [23:0]        x_in,
  input  wire logic signed [24:0] y_in,
  output logic                    done,
  output logic signed [31:0]      angle
);
  localparam int unsigned NSTEP = (STEPS < ictf_pkg::TableLen) ? STEPS : ictf_pkg::TableLen;
  localparam int unsigned SH = ictf_pkg::TableFrac - FRAC;

  logic signed [27:0] x_r, x_nxt, y_r, y_nxt;
  logic signed [33:0] z_r, z_nxt;
  logic [4:0]  i_r, i_nxt;
  logic        busy_r, busy_nxt, zero_r, zero_nxt, done_r, done_nxt;
  logic signed [27:0] xs, ys;
  logic signed [33:0] zr;

  always_comb begin
    xs = x_r >>> i_r;
    ys = y_r >>> i_r;
    x_nxt = x_r; y_nxt = y_r; z_nxt = z_r; i_nxt = i_r;
    busy_nxt = busy_r; zero_nxt = zero_r; done_nxt = 1'b0;
    if (start) begin
      x_nxt = {4'b0, x_in};
      y_nxt = {{3{y_in[24]}}, y_in};
      z_nxt = '0;
      i_nxt = '0;
      zero_nxt = (y_in == '0);
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      if (!y_r[27]) begin
        x_nxt = x_r + ys; y_nxt = y_r - xs;
        z_nxt = z_r + $signed({2'b0, ictf_pkg::atan_q24(i_r)});
      end else begin
        x_nxt = x_r - ys; y_nxt = y_r + xs;
        z_nxt = z_r - $signed({2'b0, ictf_pkg::atan_q24(i_r)});
      end
      i_nxt = i_r + 5'd1;
      if (i_r == 5'(NSTEP - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      i_r    <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      i_r    <= i_nxt;
    end
    x_r <= x_nxt; y_r <= y_nxt; z_r <= z_nxt; zero_r <= zero_nxt;
  end

  generate
    if (SH == 0) begin : g_nr
      assign zr = z_r;
    end else begin : g_r
      assign zr = (z_r + (34'sd1 <<< (SH - 1))) >>> SH;
    end
  endgenerate

  assign done  = done_r;
  assign angle = zero_r ? 32'sd0 : zr[31:0];

  a_idx: assert property (@(posedge clk) disable iff (!rst_n)
    busy_r |-> i_r < 5'(NSTEP)) else $error("cordic index overrun");
  a_done: assert property (@(posedge clk) disable iff (!rst_n)
    done |-> !busy_r) else $error("cordic done while busy");
  a_start: assert property (@(posedge clk) disable iff (!rst_n)
    start |=> busy_r) else $error("cordic did not start");
endmodule
`default_nettype wire

@@ sv/ictf_divu.sv @@
`default_nettype none
// Restoring divider by a constant 1e6, one quotient bit per cycle.
module ictf_divu (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        start,
  input  wire logic [63:0] dividend,
  output logic             done,
  output logic [63:0]      quot
);
  localparam logic [20:0] Den = 21'd1000000;
  logic [63:0] q_r, q_nxt;
  logic [20:0] rem_r, rem_nxt;
  logic [21:0] sh;
  logic [6:0]  c_r, c_nxt;
  logic        busy_r, busy_nxt, done_r, done_nxt;

  always_comb begin
    sh = {rem_r, q_r[63]};
    q_nxt = q_r; rem_nxt = rem_r; c_nxt = c_r; busy_nxt = busy_r; done_nxt = 1'b0;
    if (start) begin
      q_nxt = dividend; rem_nxt = '0; c_nxt = '0; busy_nxt = 1'b1;
    end else if (busy_r) begin
      if (sh >= {1'b0, Den}) begin
        rem_nxt = 21'(sh - {1'b0, Den});
        q_nxt   = {q_r[62:0], 1'b1};
      end else begin
        rem_nxt = sh[20:0];
        q_nxt   = {q_r[62:0], 1'b0};
      end
      c_nxt = c_r + 7'd1;
      if (c_r == 7'd63) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0; done_r <= 1'b0; c_r <= '0;
    end else begin
      busy_r <= busy_nxt; done_r <= done_nxt; c_r <= c_nxt;
    end
    q_r <= q_nxt; rem_r <= rem_nxt;
  end

  assign done = done_r;
  assign quot = q_r;

  a_rem: assert property (@(posedge clk) disable iff (!rst_n)
    busy_r |-> rem_r < Den) else $error("div remainder too large");
  a_done: assert property (@(posedge clk) disable iff (!rst_n)
    done |-> !busy_r) else $error("div done while busy");
  a_start: assert property (@(posedge clk) disable iff (!rst_n)
    start |=> busy_r) else $error("div did not start");
endmodule
`default_nettype wire
